>>> hdl/dstg_pkg.sv
// dstg_pkg: shared types and constants of the decaying sine tone generator
// used by dstg_front, dstg_back and decaying_sine_tone_generator_top
// no dependencies
package dstg_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_AMPLITUDE    = 2'd1,
    CFG_DECAY_FACTOR = 2'd2,
    CFG_SAMPLE_TOTAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] amplitude;
    logic [23:0] decay_factor;
    logic [23:0] sample_total;
  } cfg_t;

  // one queued tick
  typedef struct packed {
    logic restart;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  localparam logic [14:0] FULL_SCALE     = 15'h7FFF;
  localparam logic [23:0] ENV_ONE        = 24'h800000;
  localparam logic [31:0] PHASE_STEP_RST = 32'd0;
  localparam logic [15:0] AMPLITUDE_RST  = 16'd32768;
  localparam logic [23:0] DECAY_RST      = 24'hFFFFFF;
  localparam logic [23:0] TOTAL_RST      = 24'd44100;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // taylor divisors (2n)(2n+1) for n = 1..7
  localparam logic [7:0] TAYLOR_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

endpackage

>>> hdl/decaying_sine_tone_generator_top.sv
// decaying_sine_tone_generator_top: top level with configuration registers
// depends on dstg_pkg, dstg_front, dstg_back (and dstg_ram through dstg_back)

// Each accepted tick on the input channel yields one signed 16-bit sample of a
// sine whose amplitude decays geometrically, together with the running peak
// magnitude, the index where that peak first occurred and a flag on the final
// sample; ticks past sample_total give no result. A tick with restart set
// clears phase, envelope, count and peak before it is processed. After reset
// the quarter-wave sine table is swept into ram, one entry a cycle, for all
// SINE_TABLE_DEPTH entries (1024 by default); in_stall stays high meanwhile,
// configuration writes are taken as usual. Each sample passes the back-end
// sequencer steps in order (queue pop with table read, gain multiply, envelope
// multiply with saturation, output load and state update), one tick at a time;
// the output load waits on out_stall; a tick that gives no result is popped
// and dropped. A two-entry queue separates input acceptance from the sequencer,
// and the output register lets the next sample be computed while one waits on
// out_stall. The user writes configuration through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
module decaying_sine_tone_generator_top #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // tick channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  // sample channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic [14:0]        peak_level,
  output logic [23:0]        peak_index,
  output logic               last
);

  dstg_pkg::cfg_t    cfg;
  dstg_pkg::q_head_t head;
  logic              q_pop;
  logic              filling;

  // configuration registers, values masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= dstg_pkg::PHASE_STEP_RST;
      cfg.amplitude    <= dstg_pkg::AMPLITUDE_RST;
      cfg.decay_factor <= dstg_pkg::DECAY_RST;
      cfg.sample_total <= dstg_pkg::TOTAL_RST;
    end else if (cfg_we) begin
      unique case (dstg_pkg::cfg_reg_t'(cfg_index))
        dstg_pkg::CFG_PHASE_STEP:   cfg.phase_step   <= cfg_data;
        dstg_pkg::CFG_AMPLITUDE:    cfg.amplitude    <= cfg_data[15:0];
        dstg_pkg::CFG_DECAY_FACTOR: cfg.decay_factor <= cfg_data[23:0];
        dstg_pkg::CFG_SAMPLE_TOTAL: cfg.sample_total <= cfg_data[23:0];
      endcase
    end
  end

  // front end: tick acceptance and queue, held off during table fill
  dstg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart (restart),
    .hold    (filling),
    .head    (head),
    .q_pop   (q_pop)
  );

  // back end: tone state, sine lookup, multiply chain, result register
  dstg_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_pop     (q_pop),
    .filling   (filling),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .peak_level(peak_level),
    .peak_index(peak_index),
    .last      (last)
  );

endmodule

>>> hdl/dstg_ram.sv
// dstg_ram: generic single-write, single-read ram with registered read data
// no dependencies
module dstg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dstg_front.sv
// dstg_front: accepts ticks and holds them in a two-entry queue
// depends on dstg_pkg
module dstg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              restart,
  input  logic              hold,
  output dstg_pkg::q_head_t head,
  input  logic              q_pop
);

  logic [1:0]          cnt;
  dstg_pkg::item_t     slot0;
  dstg_pkg::item_t     slot1;
  dstg_pkg::item_t     in_item;
  logic                push;

  assign in_item.restart = restart;
  assign in_stall        = (cnt == 2'd2) || hold;
  assign push            = in_valid && !in_stall;
  assign head.valid      = (cnt != 2'd0);
  assign head.item       = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      priority if (push && q_pop) begin
        if (cnt == 2'd1) begin
          slot0 <= in_item;
        end else begin
          slot0 <= slot1;
          slot1 <= in_item;
        end
      end else if (q_pop) begin
        slot0 <= slot1;
        cnt   <= cnt - 2'd1;
      end else if (push) begin
        if (cnt == 2'd0) begin
          slot0 <= in_item;
        end else begin
          slot1 <= in_item;
        end
        cnt <= cnt + 2'd1;
      end else begin
        cnt <= cnt;
      end
    end
  end

endmodule

>>> hdl/dstg_back.sv
// dstg_back: tone state, sine table fill and lookup, sample sequencer, output register
// depends on dstg_pkg and dstg_ram
module dstg_back #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  dstg_pkg::cfg_t     cfg,
  input  dstg_pkg::q_head_t  head,
  output logic               q_pop,
  output logic               filling,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic [14:0]        peak_level,
  output logic [23:0]        peak_index,
  output logic               last
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W  = 30 + DEPTH_W;
  localparam logic [DEPTH_W-1:0] DEPTH_C   = DEPTH_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   LAST_ADDR = IDX_W'(SINE_TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } state_t;

  // quarter-wave entry k: round(32767 * sin(pi/2 * k / depth)), taylor series in Q30
  function automatic logic [15:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (dstg_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 0; n < 7; n++) begin
      term = ((term * x2) >> 30) / 64'(dstg_pkg::TAYLOR_DIV[n[2:0]]);
      if (n[0] == 1'b0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'(dstg_pkg::FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (v > 64'(dstg_pkg::FULL_SCALE)) begin
      v = 64'(dstg_pkg::FULL_SCALE);
    end
    return v[15:0];
  endfunction

  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  state_t state;
  logic [IDX_W-1:0] fill_addr;

  logic [31:0] phase_accum;
  logic [23:0] envelope;
  logic [23:0] sample_count;
  logic [14:0] peak_mag;
  logic [23:0] peak_at;

  logic        quad_odd;
  logic        quad_neg;
  logic        idx_zero;
  logic [30:0] prod1;
  logic [14:0] mag;

  logic [31:0]        phase_eff;
  logic [23:0]        count_eff;
  logic [PROD_W-1:0]  idx_prod;
  logic [IDX_W-1:0]   rd_idx;
  logic [DEPTH_W-1:0] mirror;
  logic [IDX_W-1:0]   rd_addr;
  logic [15:0]        rd_data;
  logic [14:0]        tab_mag;
  logic [54:0]        prod2;
  logic [16:0]        p_hi;
  logic [14:0]        sat_mag;
  logic [47:0]        env_prod;
  logic [23:0]        count_inc;
  logic               out_free;
  logic               out_load;
  logic               new_peak;

  dstg_ram #(
    .WIDTH(16),
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (state == ST_FILL),
    .waddr(fill_addr),
    .wdata(sine_rom[fill_addr]),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    phase_eff = head.item.restart ? 32'd0 : phase_accum;
    count_eff = head.item.restart ? 24'd0 : sample_count;
    idx_prod  = PROD_W'(phase_eff[29:0]) * PROD_W'(DEPTH_C);
    rd_idx    = idx_prod[30 +: IDX_W];
    mirror    = DEPTH_C - DEPTH_W'(rd_idx);
    rd_addr   = phase_eff[30] ? mirror[IDX_W-1:0] : rd_idx;
    tab_mag   = (quad_odd && idx_zero) ? dstg_pkg::FULL_SCALE : rd_data[14:0];
    prod2     = 55'(prod1) * 55'(envelope);
    p_hi      = prod2[54:38];
    sat_mag   = (p_hi[16:15] != 2'b00) ? dstg_pkg::FULL_SCALE : p_hi[14:0];
    env_prod  = 48'(envelope) * 48'(cfg.decay_factor);
    count_inc = sample_count + 24'd1;
    out_free  = !out_valid || !out_stall;
    out_load  = (state == ST_OUT) && out_free;
    new_peak  = mag > peak_mag;
  end

  assign q_pop   = (state == ST_IDLE) && head.valid;
  assign filling = (state == ST_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      fill_addr    <= '0;
      out_valid    <= 1'b0;
      phase_accum  <= 32'd0;
      envelope     <= dstg_pkg::ENV_ONE;
      sample_count <= 24'd0;
      peak_mag     <= 15'd0;
      peak_at      <= 24'd0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_FILL: begin
          fill_addr <= fill_addr + IDX_W'(1);
          if (fill_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head.valid) begin
            if (head.item.restart) begin
              phase_accum  <= 32'd0;
              envelope     <= dstg_pkg::ENV_ONE;
              sample_count <= 24'd0;
              peak_mag     <= 15'd0;
              peak_at      <= 24'd0;
            end
            quad_odd <= phase_eff[30];
            quad_neg <= phase_eff[31];
            idx_zero <= (rd_idx == '0);
            if (count_eff < cfg.sample_total) begin
              state <= ST_MUL1;
            end
          end
        end
        ST_MUL1: begin
          prod1 <= 31'(cfg.amplitude) * 31'(tab_mag);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          mag   <= sat_mag;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            sample_out <= quad_neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
            if (new_peak) begin
              peak_mag   <= mag;
              peak_at    <= sample_count;
              peak_level <= mag;
              peak_index <= sample_count;
            end else begin
              peak_level <= peak_mag;
              peak_index <= peak_at;
            end
            last         <= (count_inc == cfg.sample_total);
            envelope     <= env_prod[47:24];
            phase_accum  <= phase_accum + cfg.phase_step;
            sample_count <= count_inc;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !q_pop)
    else $error("tick taken during table fill");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (sample_count == $past(count_inc)))
    else $error("sample count did not advance with a result");

  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, peak_level} >=
      (sample_out[15] ? (16'd0 - sample_out) : sample_out)))
    else $error("peak level below sample magnitude");

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    envelope <= dstg_pkg::ENV_ONE)
    else $error("envelope above 1.0");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result raised outside output step");
`endif

endmodule

>>> sim/decaying_sine_tone_generator_top_tb.sv
// decaying_sine_tone_generator_top_tb: self-checking bench for the decaying sine tone generator
// predicts every sample in a small scoreboard class and drives ticks and config with plain tasks
// depends on dstg_pkg and decaying_sine_tone_generator_top
module decaying_sine_tone_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 1024;
  // a tick that yields nothing still sits in the two-entry queue until the sequencer pops it
  localparam int DRAIN_CYCLES = 32;
  // table sweep plus ~450 ticks at worst-case gap, stall and compute, many times over
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 400;

  // scoreboard: own copy of tone state and registers, queue of predicted samples
  class tone_scoreboard #(int DEPTH = 1024);
    typedef struct {
      bit signed [15:0] sample;
      bit [14:0]        peak;
      bit [23:0]        peak_at;
      bit               last;
    } tone_sample_t;

    bit [31:0] phase_step;
    bit [15:0] amplitude;
    bit [23:0] decay_factor;
    bit [23:0] sample_total;

    bit [31:0] phase;
    bit [23:0] envelope;
    bit [23:0] count;
    bit [14:0] peak_mag;
    bit [23:0] peak_idx;

    bit [15:0]    quarter_wave [DEPTH];
    tone_sample_t expected_samples [$];
    int           errors;

    // quarter-wave table: taylor series to x^15 in Q30, rounded to 15 bits
    function new();
      bit [63:0] x, x2, term, sum, v;
      for (int k = 0; k < DEPTH; k++) begin
        x    = (64'd1686629713 * 64'(k)) / 64'(DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
          if (n % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        quarter_wave[k] = (v > 64'd32767) ? 16'd32767 : v[15:0];
      end
      phase_step   = dstg_pkg::PHASE_STEP_RST;
      amplitude    = dstg_pkg::AMPLITUDE_RST;
      decay_factor = dstg_pkg::DECAY_RST;
      sample_total = dstg_pkg::TOTAL_RST;
      errors       = 0;
      clear_tone();
    endfunction

    function void clear_tone();
      phase    = '0;
      envelope = dstg_pkg::ENV_ONE;
      count    = '0;
      peak_mag = '0;
      peak_idx = '0;
    endfunction

    function void set_reg(dstg_pkg::cfg_reg_t idx, bit [31:0] data);
      case (idx)
        dstg_pkg::CFG_PHASE_STEP:   phase_step   = data;
        dstg_pkg::CFG_AMPLITUDE:    amplitude    = data[15:0];
        dstg_pkg::CFG_DECAY_FACTOR: decay_factor = data[23:0];
        dstg_pkg::CFG_SAMPLE_TOTAL: sample_total = data[23:0];
        default: ;
      endcase
    endfunction

    function int sine_at(bit [31:0] ph);
      bit [63:0] idx;
      int        mag;
      idx = (64'(ph[29:0]) * 64'(DEPTH)) >> 30;
      if (idx >= 64'(DEPTH)) idx = 64'(DEPTH - 1);
      if (ph[30]) mag = (idx == 0) ? 32767 : int'(quarter_wave[DEPTH - int'(idx)]);
      else mag = int'(quarter_wave[int'(idx)]);
      return ph[31] ? -mag : mag;
    endfunction

    // one accepted tick: predict its sample, if the tone is still running
    function void note_tick(bit restart);
      int           s;
      bit           neg;
      bit [63:0]    p;
      bit [14:0]    mag;
      int           signed_mag;
      tone_sample_t e;
      if (restart) clear_tone();
      if (count >= sample_total) return;
      s   = sine_at(phase);
      neg = s < 0;
      p   = 64'(amplitude) * 64'(neg ? -s : s) * 64'(envelope);
      p   = p >> 38;
      mag = (p > 64'd32767) ? 15'h7FFF : p[14:0];
      if (mag > peak_mag) begin
        peak_mag = mag;
        peak_idx = count;
      end
      signed_mag = neg ? -int'(mag) : int'(mag);
      e.sample   = 16'(signed_mag);
      e.peak     = peak_mag;
      e.peak_at  = peak_idx;
      e.last     = (25'(count) + 25'd1) == 25'(sample_total);
      expected_samples.push_back(e);
      envelope = 24'((64'(envelope) * 64'(decay_factor)) >> 24);
      phase    = phase + phase_step;
      count    = count + 24'd1;
    endfunction

    function void check_sample(logic [15:0] smp, logic [14:0] pk, logic [23:0] pk_at,
                               logic lst);
      tone_sample_t e;
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: sample_out %0d with nothing pending", $signed(smp));
        errors++;
        return;
      end
      e = expected_samples.pop_front();
      if (smp !== e.sample) begin
        $error("sample_out: expected %0d, got %0d", e.sample, $signed(smp));
        errors++;
      end
      if (pk !== e.peak) begin
        $error("peak_level: expected %0d, got %0d", e.peak, pk);
        errors++;
      end
      if (pk_at !== e.peak_at) begin
        $error("peak_index: expected %0d, got %0d", e.peak_at, pk_at);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  // every input starts at a known value
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = dstg_pkg::CFG_PHASE_STEP;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic [14:0]        peak_level;
  logic [23:0]        peak_index;
  logic               last;

  // no idling on either side once this is set
  bit  calm = 1'b0;
  int  cycles = 0;
  int  ticks_sent = 0;

  tone_scoreboard #(TABLE_DEPTH) sb;

  decaying_sine_tone_generator_top #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .peak_level (peak_level),
    .peak_index (peak_index),
    .last       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing sample ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output side: back-pressure in random bursts, free-running when calm
  initial begin
    int burst;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        burst = $urandom_range(1, 14);
        out_stall <= ($urandom_range(0, 1) == 1);
        repeat (burst) @(posedge clk);
      end
    end
  end

  // sample monitor: values seen here are the ones present before the edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_sample(sample_out, peak_level, peak_index, last);
  end

  // one register write, taken at the next edge; cfg_we stays up for back-to-back writes
  task automatic write_reg(dstg_pkg::cfg_reg_t idx, bit [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_tone(bit [31:0] step_d, bit [31:0] amp_d, bit [31:0] decay_d,
                              bit [31:0] total_d);
    write_reg(dstg_pkg::CFG_PHASE_STEP, step_d);
    write_reg(dstg_pkg::CFG_AMPLITUDE, amp_d);
    write_reg(dstg_pkg::CFG_DECAY_FACTOR, decay_d);
    write_reg(dstg_pkg::CFG_SAMPLE_TOTAL, total_d);
    cfg_we <= 1'b0;
  endtask

  // one tick transaction, with an optional leading gap; valid stays up afterwards
  task automatic send_tick(bit r);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= r;
    do @(posedge clk); while (in_stall);
    sb.note_tick(r);
    ticks_sent++;
  endtask

  task automatic end_ticks();
    in_valid <= 1'b0;
  endtask

  // block is idle once every sample has come and trailing no-result ticks have drained
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // a random tone: first tick usually restarts, later ones rarely do
  task automatic random_tone(int n_ticks);
    bit [31:0] step_d, amp_d, decay_d, total_d;
    case ($urandom_range(0, 3))
      0:       step_d = 32'd0;
      1:       step_d = 32'hFFFF_FFFF;
      default: step_d = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       amp_d = 32'd0;
      1:       amp_d = 32'd32768;
      2:       amp_d = 32'd65535;
      default: amp_d = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 4))
      0:       decay_d = 32'hFF_FFFF;
      1:       decay_d = 32'd0;
      2:       decay_d = $urandom_range(32'hE0_0000, 32'hFF_FFFF);
      default: decay_d = $urandom_range(0, 32'hFF_FFFF);
    endcase
    case ($urandom_range(0, 15))
      0:       total_d = 32'hFF_FFFF;
      1:       total_d = 32'd0;
      default: total_d = $urandom_range(1, 60);
    endcase
    // junk above each register's width must be dropped by the block
    amp_d[31:16]   = 16'($urandom);
    decay_d[31:24] = 8'($urandom);
    total_d[31:24] = 8'($urandom);
    program_tone(step_d, amp_d, decay_d, total_d);
    send_tick($urandom_range(0, 3) != 0);
    for (int i = 1; i < n_ticks; i++)
      send_tick($urandom_range(0, 11) == 0);
    end_ticks();
    wait_idle();
  endtask

  initial begin
    sb = new;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // quarter-turn step hits every quadrant boundary at full scale; ticks past the
    // end give nothing, then a restart brings the tone back from index zero
    program_tone(32'h4000_0000, 32'd32768, 32'hFF_FFFF, 32'd6);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    end_ticks();
    wait_idle();

    // gain above one; zero decay kills the envelope after the first sample, at phase zero, so nothing saturates
    program_tone(32'h2000_0000, 32'd65535, 32'd0, 32'd3);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    end_ticks();
    wait_idle();

    // zero gain, full phase step, half decay, one-sample tone
    program_tone(32'hFFFF_FFFF, 32'd0, 32'h80_0000, 32'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    end_ticks();
    wait_idle();

    // length written as zero through masked data: even a restart yields nothing
    program_tone(32'h0000_0001, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFF00_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    end_ticks();
    wait_idle();

    // random tones; the tail runs with no idling on either side
    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      if (ticks_sent >= RANDOM_TICKS - 60) calm = 1'b1;
      random_tone($urandom_range(20, 50));
    end

    wait_idle();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/dstg_pkg.sv
hdl/dstg_ram.sv
hdl/dstg_front.sv
hdl/dstg_back.sv
hdl/decaying_sine_tone_generator_top.sv
sim/decaying_sine_tone_generator_top_tb.sv
